[rtl/core/uitp_pkg.sv]
`default_nettype none

package uitp_pkg;

  localparam int VALUE_W  = 32;
  localparam int OFFSET_W = 16;
  localparam int RADIX_W  = 6;
  localparam int PROD_W   = VALUE_W + RADIX_W;

  localparam logic [RADIX_W-1:0] MAX_BASE  = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] NOT_DIGIT = 6'd63;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BAD_BASE = 2'd2;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;

  typedef struct packed {
    logic [7:0]         ch;
    logic               first;
    logic [RADIX_W-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    logic [1:0]          status;
  } out_item_t;

  function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = c - CH_ZERO;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
        t = c - CH_UPPER_A + 8'd10;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        t = c - CH_LOWER_A + 8'd10;
      end else begin
        t = {2'b00, NOT_DIGIT};
      end
      digit_of = t[RADIX_W-1:0];
    end
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [OFFSET_W-1:0] offset_inc(input logic [OFFSET_W-1:0] p);
    offset_inc = (&p) ? p : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

[rtl/core/uitp_in_stage.sv]
`default_nettype none

module uitp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire uitp_pkg::in_item_t in_item,
  input  wire logic               adv,
  output logic                    s1_valid,
  output uitp_pkg::in_item_t      s1_item
);

  logic               s1_valid_r, s1_valid_nxt;
  uitp_pkg::in_item_t s1_item_r;
  logic               accept;

  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

[rtl/core/uitp_step.sv]
`default_nettype none

module uitp_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire uitp_pkg::in_item_t item,
  output logic                    res_valid,
  output uitp_pkg::out_item_t     res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_HEX    = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  logic [2:0]                      phase_r, phase_nxt;
  logic [uitp_pkg::VALUE_W-1:0]    acc_r, acc_nxt;
  logic [uitp_pkg::RADIX_W-1:0]    base_r, base_nxt;
  logic [uitp_pkg::OFFSET_W-1:0]   pos_r, pos_nxt;
  logic [uitp_pkg::OFFSET_W-1:0]   zend_r, zend_nxt;
  logic                            seen_r, seen_nxt;

  logic [2:0]                      ph_w;
  logic [uitp_pkg::VALUE_W-1:0]    acc_w;
  logic [uitp_pkg::RADIX_W-1:0]    base_w;
  logic [uitp_pkg::OFFSET_W-1:0]   pos_w;
  logic [uitp_pkg::OFFSET_W-1:0]   zend_w;
  logic                            seen_w;
  logic [uitp_pkg::RADIX_W-1:0]    d;
  logic [uitp_pkg::RADIX_W-1:0]    dig_base;
  logic                            go_digit;
  logic                            bad_base;
  logic [uitp_pkg::PROD_W-1:0]     prod;
  logic                            ovf;

  assign bad_base = item.first &&
                    (item.radix == 6'd1 || item.radix > uitp_pkg::MAX_BASE);

  always_comb begin
    ph_w   = item.first ? PH_SPACE : phase_r;
    acc_w  = item.first ? '0 : acc_r;
    base_w = item.first ? item.radix : base_r;
    pos_w  = item.first ? '0 : pos_r;
    zend_w = item.first ? '0 : zend_r;
    seen_w = item.first ? 1'b0 : seen_r;
    d      = uitp_pkg::digit_of(item.ch);

    phase_nxt = ph_w;
    acc_nxt   = acc_w;
    base_nxt  = base_w;
    pos_nxt   = pos_w;
    zend_nxt  = zend_w;
    seen_nxt  = seen_w;
    dig_base  = base_w;
    go_digit  = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (bad_base) begin
      phase_nxt  = PH_IDLE;
      res_valid  = 1'b1;
      res.status = uitp_pkg::ST_BAD_BASE;
    end else if (ph_w != PH_IDLE) begin
      pos_nxt = uitp_pkg::offset_inc(pos_w);
      case (ph_w)
        PH_SPACE: begin
          if (uitp_pkg::is_space(item.ch)) begin
            phase_nxt = PH_SPACE;
          end else if ((base_w == '0 || base_w == uitp_pkg::BASE_HEX) &&
                       item.ch == uitp_pkg::CH_ZERO) begin
            acc_nxt   = '0;
            seen_nxt  = 1'b1;
            zend_nxt  = uitp_pkg::offset_inc(pos_w);
            phase_nxt = PH_ZERO;
          end else begin
            dig_base = (base_w == '0) ? uitp_pkg::BASE_DEC : base_w;
            go_digit = 1'b1;
          end
        end
        PH_ZERO: begin
          if (item.ch == uitp_pkg::CH_LOWER_X || item.ch == uitp_pkg::CH_UPPER_X) begin
            base_nxt  = uitp_pkg::BASE_HEX;
            phase_nxt = PH_HEX;
          end else begin
            dig_base = (base_w == '0) ? uitp_pkg::BASE_OCT : base_w;
            go_digit = 1'b1;
          end
        end
        PH_HEX: begin
          if (d >= uitp_pkg::BASE_HEX) begin
            phase_nxt      = PH_IDLE;
            res_valid      = 1'b1;
            res.end_offset = zend_w;
            res.status     = uitp_pkg::ST_OK;
          end else begin
            go_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          go_digit = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    prod = uitp_pkg::PROD_W'(acc_w) * uitp_pkg::PROD_W'(dig_base) +
           uitp_pkg::PROD_W'(d);
    ovf  = |prod[uitp_pkg::PROD_W-1:uitp_pkg::VALUE_W];

    if (go_digit) begin
      base_nxt = dig_base;
      if (dig_base < 6'd2 || d >= dig_base) begin
        phase_nxt      = PH_IDLE;
        res_valid      = 1'b1;
        res.value      = acc_w;
        res.end_offset = seen_w ? pos_w : '0;
        res.status     = uitp_pkg::ST_OK;
      end else if (ovf) begin
        phase_nxt      = PH_IDLE;
        res_valid      = 1'b1;
        res.value      = '1;
        res.end_offset = pos_w;
        res.status     = uitp_pkg::ST_OVERFLOW;
      end else begin
        acc_nxt   = prod[uitp_pkg::VALUE_W-1:0];
        seen_nxt  = 1'b1;
        phase_nxt = PH_DIGITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      base_r  <= '0;
      pos_r   <= '0;
      zend_r  <= '0;
      seen_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      pos_r   <= pos_nxt;
      zend_r  <= zend_nxt;
      seen_r  <= seen_nxt;
    end
  end

  a_end_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> phase_r == PH_IDLE)
    else $error("string still active after its result");

  a_bad_base_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.status == uitp_pkg::ST_BAD_BASE |->
      res.value == '0 && res.end_offset == '0)
    else $error("invalid base result carries data");

  a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.status == uitp_pkg::ST_OVERFLOW |-> &res.value)
    else $error("overflow result not saturated");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.status == uitp_pkg::ST_OK && res.end_offset == '0 |->
      res.value == '0)
    else $error("nonzero value with no digits taken");

endmodule

`default_nettype wire

[rtl/core/uitp_out_stage.sv]
`default_nettype none

module uitp_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s1_valid,
  input  wire logic                res_valid,
  input  wire uitp_pkg::out_item_t res,
  output logic                     adv,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output uitp_pkg::out_item_t      out_item
);

  logic                out_valid_r, out_valid_nxt;
  uitp_pkg::out_item_t out_item_r;
  logic                load;

  assign adv  = !out_valid_r || !out_stall;
  assign load = adv && s1_valid && res_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[rtl/core/unsigned_integer_text_parser_unit.sv]
// the input register holds a character; the digit multiply-add and limit compare on it are
// combinational; the result is registered in out_item; one character per cycle if not stalled
// a held result keeps the input register full, which then stalls the input
// a string gives at most one result: at its digits' end, on overflow, or at once on a bad base
// rst_n is synchronous, active low; clears the pipeline valids and the parse state to idle
`default_nettype none

module unsigned_integer_text_parser_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire uitp_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output uitp_pkg::out_item_t      out_item
);

  logic                adv;
  logic                s1_valid;
  uitp_pkg::in_item_t  s1_item;
  logic                res_valid;
  uitp_pkg::out_item_t res;

  uitp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  uitp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_valid && adv),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  uitp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
